### sv/rhc_pkg.sv
// ----------------------------------------------------------------------------
// rhc_pkg
// Shared constants and types for the RGB to HSL converter.
// ----------------------------------------------------------------------------
package rhc_pkg;

  // Default widths of one channel and of the fixed-point fraction
  localparam int CHANNEL_BITS_DEF  = 8;
  localparam int FRACTION_BITS_DEF = 16;

  // Depth of the queue between the classifier and the divider pipeline
  localparam int QUEUE_DEPTH = 4;

  // Valid/ready pair of one internal item channel
  typedef struct packed {
    logic valid;
    logic ready;
  } link_t;

endpackage

### sv/rgb_to_hsl_converter.sv
// ----------------------------------------------------------------------------
// rgb_to_hsl_converter
// Converts one RGB pixel to fixed-point hue, saturation and lightness.
// ----------------------------------------------------------------------------
// Input channel: drive red, green, blue and raise push; the item is taken at
// a clock edge with push high and full low.
// Result channel: while empty is low, hue, saturation and lightness hold the
// oldest result; raise pop to take it.
// Throughput: one item per cycle, sustained, while pop stays high. Each
// divider retires one quotient bit per pipeline stage, FRACTION_BITS+1
// stages in all.
// An item passes the classify register, the queue, the divider stages and
// the result register before empty goes low.
// Reset (rst, synchronous) empties the classifier, queue and pipeline.
// When the consumer stalls, the divider pipeline freezes, the queue between
// the classifier and the dividers fills, and then full rises.
// ----------------------------------------------------------------------------
module rgb_to_hsl_converter #(
  parameter int CHANNEL_BITS  = rhc_pkg::CHANNEL_BITS_DEF,
  parameter int FRACTION_BITS = rhc_pkg::FRACTION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  output logic                     full,
  input  logic [CHANNEL_BITS-1:0]  red,
  input  logic [CHANNEL_BITS-1:0]  green,
  input  logic [CHANNEL_BITS-1:0]  blue,
  output logic                     empty,
  input  logic                     pop,
  output logic [FRACTION_BITS:0]   hue,
  output logic [FRACTION_BITS-1:0] saturation,
  output logic [FRACTION_BITS-1:0] lightness
);

  localparam int W = 4 * CHANNEL_BITS + 5;

  rhc_pkg::link_t f_link;
  logic           q_wr_ready;
  logic [W-1:0]   f_item;
  logic           b_ready;
  logic           q_valid;
  logic [W-1:0]   q_item;

  rhc_front #(.CHANNEL_BITS(CHANNEL_BITS), .W(W)) u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .red     (red),
    .green   (green),
    .blue    (blue),
    .q_link  (f_link),
    .q_ready (q_wr_ready),
    .item    (f_item)
  );

  rhc_queue #(.W(W), .DEPTH(rhc_pkg::QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .wr_link_in (f_link),
    .wr_ready   (q_wr_ready),
    .wr_data    (f_item),
    .rd_ready   (b_ready),
    .rd_valid   (q_valid),
    .rd_data    (q_item)
  );

  rhc_back #(
    .CHANNEL_BITS  (CHANNEL_BITS),
    .FRACTION_BITS (FRACTION_BITS),
    .W             (W)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_ready    (b_ready),
    .item       (q_item),
    .empty      (empty),
    .pop        (pop),
    .hue        (hue),
    .saturation (saturation),
    .lightness  (lightness)
  );

endmodule

### sv/rhc_div.sv
// ----------------------------------------------------------------------------
// rhc_div
// Pipelined restoring divider, one quotient bit per stage.
// The caller guarantees dividend < divisor * 2^QW.
// ----------------------------------------------------------------------------
module rhc_div #(
  parameter int NW = 24,
  parameter int DW = 8,
  parameter int QW = 17
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic [QW-1:0] quotient
);

  logic [DW-1:0] s_rem [0:QW-1];
  logic [QW-1:0] s_low [0:QW-1];
  logic [QW-1:0] s_quo [0:QW-1];
  logic [DW-1:0] s_dvs [0:QW-1];
  logic [DW-1:0] rem   [0:QW-1];
  logic [QW-1:0] low   [0:QW-1];
  logic [QW-1:0] quo   [0:QW-1];
  logic [DW-1:0] dvs   [0:QW-1];

  genvar k;
  generate
    for (k = 0; k < QW; k++) begin : g_stage
      logic [DW:0] trial;
      logic        ge;

      // Feed the first stage from the ports, the others from the stage before
      if (k == 0) begin : g_head
        assign s_rem[k] = DW'(dividend >> QW);
        assign s_low[k] = dividend[QW-1:0];
        assign s_quo[k] = '0;
        assign s_dvs[k] = divisor;
      end else begin : g_body
        assign s_rem[k] = rem[k-1];
        assign s_low[k] = low[k-1];
        assign s_quo[k] = quo[k-1];
        assign s_dvs[k] = dvs[k-1];
      end

      // Bring down one bit, subtract when it fits
      assign trial = {s_rem[k], s_low[k][QW-1]};
      assign ge    = trial >= {1'b0, s_dvs[k]};

      always_ff @(posedge clk) begin
        if (en) begin
          rem[k] <= ge ? DW'(trial - {1'b0, s_dvs[k]}) : trial[DW-1:0];
          low[k] <= {s_low[k][QW-2:0], 1'b0};
          quo[k] <= {s_quo[k][QW-2:0], ge};
          dvs[k] <= s_dvs[k];
        end
      end
    end
  endgenerate

  assign quotient = quo[QW-1];

endmodule

### sv/rhc_queue.sv
// ----------------------------------------------------------------------------
// rhc_queue
// Short register queue between the classifier and the divider pipeline.
// ----------------------------------------------------------------------------
module rhc_queue #(
  parameter int W     = 37,
  parameter int DEPTH = rhc_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  rhc_pkg::link_t  wr_link_in,
  output logic            wr_ready,
  input  logic [W-1:0]    wr_data,
  input  logic            rd_ready,
  output logic            rd_valid,
  output logic [W-1:0]    rd_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  slots [0:DEPTH-1];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          wr;
  logic          rd;

  assign wr_ready = count != CW'(DEPTH);
  assign rd_valid = count != '0;
  assign wr       = wr_link_in.valid && wr_ready;
  assign rd       = rd_ready && rd_valid;
  assign rd_data  = slots[rd_ptr];

  // Store an item at the write pointer
  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr + 1'b1);
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr + 1'b1);
      end
      if (wr && !rd) begin
        count <= CW'(count + 1'b1);
      end else if (rd && !wr) begin
        count <= CW'(count - 1'b1);
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH)) else $error("queue count beyond depth");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (wr && !rd) |=> count == CW'($past(count) + 1'b1)) else $error("queue lost a write");

  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (rd && !wr) |=> count == CW'($past(count) - 1'b1)) else $error("queue lost a read");

endmodule

### sv/rhc_front.sv
// ----------------------------------------------------------------------------
// rhc_front
// Accept a pixel, find max and min, and form the sextant numerator and
// the saturation divisor the back end needs.
// ----------------------------------------------------------------------------
module rhc_front #(
  parameter int CHANNEL_BITS = rhc_pkg::CHANNEL_BITS_DEF,
  parameter int W            = 4 * CHANNEL_BITS + 5
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  output logic                    full,
  input  logic [CHANNEL_BITS-1:0] red,
  input  logic [CHANNEL_BITS-1:0] green,
  input  logic [CHANNEL_BITS-1:0] blue,
  output rhc_pkg::link_t          q_link,
  input  logic                    q_ready,
  output logic [W-1:0]            item
);

  localparam int CB = CHANNEL_BITS;
  localparam logic [CB:0] CMAX = {1'b0, {CB{1'b1}}};

  logic          valid;
  logic          accept;
  logic [CB-1:0] v;
  logic [CB-1:0] m;
  logic [CB-1:0] vm;
  logic [CB:0]   sum;
  logic [CB-1:0] den;
  logic [CB+2:0] vm3;
  logic [CB+2:0] vm5;
  logic [CB+2:0] num;
  logic          gray;

  assign full   = valid && !q_ready;
  assign accept = push && !full;

  // Classify the pixel
  always_comb begin
    v = (red > green) ? red : green;
    if (blue > v) v = blue;
    m = (red < green) ? red : green;
    if (blue < m) m = blue;
    vm   = v - m;
    sum  = {1'b0, v} + {1'b0, m};
    den  = (sum <= CMAX) ? sum[CB-1:0] : CB'((CMAX << 1) - sum);
    vm3  = (CB+3)'({vm, 1'b0}) + (CB+3)'(vm);
    vm5  = (CB+3)'({vm, 2'b0}) + (CB+3)'(vm);
    gray = v == m;
    if (red == v) begin
      num = (green == m) ? vm5 + (CB+3)'(v - blue) : (CB+3)'(vm - (v - green));
    end else if (green == v) begin
      num = (blue == m) ? (CB+3)'(vm) + (CB+3)'(v - red) : vm3 - (CB+3)'(v - blue);
    end else begin
      num = (red == m) ? vm3 + (CB+3)'(v - green) : vm5 - (CB+3)'(v - red);
    end
  end

  // Hold the classified item until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (accept) begin
      valid <= 1'b1;
    end else if (q_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= {gray, vm, sum, den, num};
    end
  end

  assign q_link.valid = valid;
  assign q_link.ready = q_ready;

endmodule

### sv/rhc_back.sv
// ----------------------------------------------------------------------------
// rhc_back
// Divider pipeline for hue and saturation, a matching delay line for
// lightness, and the result register seen by the consumer.
// ----------------------------------------------------------------------------
module rhc_back #(
  parameter int CHANNEL_BITS  = rhc_pkg::CHANNEL_BITS_DEF,
  parameter int FRACTION_BITS = rhc_pkg::FRACTION_BITS_DEF,
  parameter int W             = 4 * CHANNEL_BITS + 5
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     q_valid,
  output logic                     q_ready,
  input  logic [W-1:0]             item,
  output logic                     empty,
  input  logic                     pop,
  output logic [FRACTION_BITS:0]   hue,
  output logic [FRACTION_BITS-1:0] saturation,
  output logic [FRACTION_BITS-1:0] lightness
);

  localparam int CB = CHANNEL_BITS;
  localparam int FB = FRACTION_BITS;
  localparam int QW = FB + 1;

  // Lightness is sum * (2^FB - 1) / (2 * (2^CB - 1)); take it as a
  // multiply by a rounded-up reciprocal, exact for every sum up to 2C
  localparam int LS = 2 * CB + 2;
  localparam int KW = CB + FB + 2;
  localparam int PW = CB + 1 + KW;
  localparam longint unsigned FONE   = (64'd1 << FB) - 64'd1;
  localparam longint unsigned TWO_CV = (64'd1 << (CB + 1)) - 64'd2;
  localparam longint unsigned LIG_K  = (((64'd1 << LS) * FONE) + TWO_CV - 64'd1) / TWO_CV;

  logic          en;
  logic          take;
  logic          out_valid;
  logic [QW-1:0] vld_pipe;
  logic [QW-1:0] gray_pipe;
  logic [CB:0]   sum_pipe [0:QW-1];
  logic          gray;
  logic [CB-1:0] vm;
  logic [CB:0]   sum;
  logic [CB-1:0] den;
  logic [CB+2:0] num;
  logic [CB+2:0] vm6;
  logic [QW-1:0] hue_q;
  logic [QW-1:0] sat_q;
  logic [PW-1:0] lig_prod;

  assign {gray, vm, sum, den, num} = item;
  assign vm6 = (CB+3)'({vm, 2'b0}) + (CB+3)'({vm, 1'b0});

  // Advance the whole pipeline unless the result waits for the consumer
  assign en      = !out_valid || pop;
  assign q_ready = en;
  assign take    = en && q_valid;
  assign empty   = !out_valid;

  rhc_div #(.NW(CB + 3 + FB), .DW(CB + 3), .QW(QW)) u_hue_div (
    .clk      (clk),
    .en       (en),
    .dividend ({num, {FB{1'b0}}}),
    .divisor  (vm6),
    .quotient (hue_q)
  );

  rhc_div #(.NW(CB + FB), .DW(CB), .QW(QW)) u_sat_div (
    .clk      (clk),
    .en       (en),
    .dividend ((CB+FB)'({vm, {FB{1'b0}}}) - (CB+FB)'(vm)),
    .divisor  (den),
    .quotient (sat_q)
  );

  // Track item valid and gray flag alongside the dividers
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_pipe  <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld_pipe  <= {vld_pipe[QW-2:0], take};
      out_valid <= vld_pipe[QW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gray_pipe <= {gray_pipe[QW-2:0], gray};
    end
  end

  // Delay the channel sum so lightness lines up with the dividers
  always_ff @(posedge clk) begin
    if (en) begin
      sum_pipe[0] <= sum;
      for (int i = 1; i < QW; i++) begin
        sum_pipe[i] <= sum_pipe[i-1];
      end
    end
  end

  assign lig_prod = PW'(sum_pipe[QW-1]) * PW'(LIG_K[KW-1:0]);

  // Load the result register, force gray pixels to zero hue and saturation
  always_ff @(posedge clk) begin
    if (en) begin
      hue        <= gray_pipe[QW-1] ? '0 : hue_q;
      saturation <= gray_pipe[QW-1] ? '0 : sat_q[FB-1:0];
      lightness  <= lig_prod[LS +: FB];
    end
  end

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> hue <= {1'b1, {FB{1'b0}}}) else $error("hue beyond one turn");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pop) |=> out_valid) else $error("waiting result dropped");

  a_take_space: assert property (@(posedge clk) disable iff (rst)
    take |-> (!out_valid || pop)) else $error("item taken while pipeline stalled");

endmodule

### tb/tb_rgb_to_hsl_converter.sv
// ----------------------------------------------------------------------------
// tb_rgb_to_hsl_converter
// Drives RGB pixels into the converter with random gaps and output stalls,
// predicts hue, saturation and lightness for each accepted item, and checks
// every result in order, field by field.
// ----------------------------------------------------------------------------
module tb_rgb_to_hsl_converter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = rhc_pkg::CHANNEL_BITS_DEF;
  localparam int FB = rhc_pkg::FRACTION_BITS_DEF;
  localparam int NUM_RANDOM = 2000;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_STALL = 300;

  typedef struct packed {
    logic [CB-1:0] r;
    logic [CB-1:0] g;
    logic [CB-1:0] b;
  } pixel_t;

  typedef struct packed {
    logic [FB:0]   h;
    logic [FB-1:0] s;
    logic [FB-1:0] l;
  } hsl_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic [CB-1:0] red = '0, green = '0, blue = '0;
  logic full, empty;
  logic [FB:0] hue;
  logic [FB-1:0] saturation, lightness;

  pixel_t pending_pixels[$];
  hsl_t expected_hsl[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int n_checked = 0;
  int n_total = 0;
  int send_gap = 0;
  int recv_gap = 0;
  bit hold_long = 1'b0;
  logic in_acc = 1'b0;
  logic out_acc = 1'b0;

  rgb_to_hsl_converter u_top (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .red(red), .green(green), .blue(blue),
    .empty(empty), .pop(pop),
    .hue(hue), .saturation(saturation), .lightness(lightness)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Compute the expected HSL triple of one pixel
  function automatic hsl_t convert_pixel(pixel_t p);
    longint unsigned r, g, b, v, m, vm, sum, num, cmax, fone;
    hsl_t res;
    r = p.r; g = p.g; b = p.b;
    cmax = (64'd1 << CB) - 1;
    fone = (64'd1 << FB) - 1;
    v = (r > g) ? r : g;
    if (b > v) v = b;
    m = (r < g) ? r : g;
    if (b < m) m = b;
    sum = v + m;
    res.l = FB'((sum * fone) / (2 * cmax));
    res.h = '0;
    res.s = '0;
    if (v != m) begin
      vm = v - m;
      if (sum <= cmax) res.s = FB'((vm * fone) / sum);
      else res.s = FB'((vm * fone) / (2 * cmax - sum));
      // Pick the sextant; red wins ties over green, green over blue
      if (r == v) num = (g == m) ? 5 * vm + (v - b) : vm - (v - g);
      else if (g == v) num = (b == m) ? vm + (v - r) : 3 * vm - (v - b);
      else num = (r == m) ? 3 * vm + (v - g) : 5 * vm - (v - r);
      res.h = (FB+1)'((num << FB) / (6 * vm));
    end
    return res;
  endfunction

  // Sample handshakes at the rising edge
  always @(posedge clk) begin
    in_acc  <= !rst && push && !full;
    out_acc <= !rst && pop && !empty;
    if (!rst && push && !full) expected_hsl.push_back(convert_pixel({red, green, blue}));
  end

  // Driver: hold an item until taken, then wait its drawn gap
  always @(negedge clk) begin
    pixel_t p;
    if (rst) push <= 1'b0;
    else if (!push || in_acc) begin
      if (send_gap > 0) begin
        send_gap = send_gap - 1;
        push <= 1'b0;
      end else if (pending_pixels.size() > 0) begin
        p = pending_pixels.pop_front();
        red <= p.r; green <= p.g; blue <= p.b;
        push <= 1'b1;
        send_gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 11);
      end else push <= 1'b0;
    end
  end

  // Monitor: check results in order
  always @(posedge clk) begin
    hsl_t want;
    if (rst) idle_cycles <= 0;
    else begin
      if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (pop && !empty) begin
        n_checked++;
        if (expected_hsl.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result h=%0d s=%0d l=%0d",
                                         hue, saturation, lightness);
        end else begin
          want = expected_hsl.pop_front();
          if (want.h !== hue || want.s !== saturation || want.l !== lightness) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected h=%0d s=%0d l=%0d got h=%0d s=%0d l=%0d",
                       want.h, want.s, want.l, hue, saturation, lightness);
          end
        end
      end
    end
  end

  // Receiver: after each taken result wait a drawn number of cycles
  always @(negedge clk) begin
    if (rst || hold_long) pop <= 1'b0;
    else if (!pop || out_acc) begin
      if (recv_gap > 0) begin
        recv_gap = recv_gap - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        recv_gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 11);
      end
    end
  end

  // Hold off the receiver once long enough for the block to fill and stall
  initial begin
    wait (!rst);
    repeat (200) @(posedge clk);
    hold_long = 1'b1;
    repeat (LONG_STALL) @(posedge clk);
    hold_long = 1'b0;
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Stimulus and end of run
  initial begin
    pixel_t p;
    int kind;
    pending_pixels.push_back('{8'd0, 8'd0, 8'd0});
    pending_pixels.push_back('{8'd255, 8'd255, 8'd255});
    pending_pixels.push_back('{8'd128, 8'd128, 8'd128});
    pending_pixels.push_back('{8'd255, 8'd0, 8'd0});
    pending_pixels.push_back('{8'd0, 8'd255, 8'd0});
    pending_pixels.push_back('{8'd0, 8'd0, 8'd255});
    pending_pixels.push_back('{8'd255, 8'd255, 8'd0});
    pending_pixels.push_back('{8'd0, 8'd255, 8'd255});
    pending_pixels.push_back('{8'd255, 8'd0, 8'd255});
    pending_pixels.push_back('{8'd255, 8'd0, 8'd1});
    pending_pixels.push_back('{8'd255, 8'd1, 8'd0});
    pending_pixels.push_back('{8'd1, 8'd255, 8'd0});
    pending_pixels.push_back('{8'd0, 8'd1, 8'd255});
    pending_pixels.push_back('{8'd1, 8'd0, 8'd255});
    pending_pixels.push_back('{8'd128, 8'd127, 8'd127});
    pending_pixels.push_back('{8'd127, 8'd128, 8'd128});
    pending_pixels.push_back('{8'd255, 8'd254, 8'd254});
    pending_pixels.push_back('{8'd1, 8'd0, 8'd0});
    pending_pixels.push_back('{8'd200, 8'd200, 8'd10});
    pending_pixels.push_back('{8'd10, 8'd200, 8'd200});
    for (int i = 0; i < NUM_RANDOM; i++) begin
      kind = $urandom_range(0, 9);
      p = pixel_t'($urandom);
      // Bias toward ties and near-gray pixels
      if (kind == 0) p.g = p.r;
      else if (kind == 1) p.b = p.g;
      else if (kind == 2) p.b = p.r;
      else if (kind == 3) begin
        p.g = p.r ^ CB'($urandom_range(0, 1));
        p.b = p.r ^ CB'($urandom_range(0, 1));
      end
      pending_pixels.push_back(p);
    end
    n_total = pending_pixels.size();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    while (n_checked < n_total) @(posedge clk);
    repeat (FB + 10) @(posedge clk);
    if (mismatches == 0 && expected_hsl.size() == 0 && n_checked == n_total)
      $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
